// File: rtl/core/skin_weight_top4_accumulator_defines.svh
// assertion macros used by the checker of the skin weight accumulator
`ifndef SKIN_WEIGHT_TOP4_ACCUMULATOR_DEFINES_SVH
`define SKIN_WEIGHT_TOP4_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define SWTA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define SWTA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/swta_pkg.sv
package swta_pkg;

	// store geometry
	localparam int VERTEX_DEPTH = 4096;
	localparam int SLOT_COUNT   = 4;
	localparam int JOINT_LIMIT  = 256;
	localparam int EMIT_SLOTS   = 4;

	// field widths
	localparam int CMD_W    = 2;
	localparam int VTX_W    = 12;
	localparam int JOINT_W  = 8;
	localparam int WEIGHT_W = 16;

	// input word layout: vertex_index, joint_index, weight
	localparam int IN_VTX_LSB   = 0;
	localparam int IN_JOINT_LSB = IN_VTX_LSB + VTX_W;
	localparam int IN_WT_LSB    = IN_JOINT_LSB + JOINT_W;
	localparam int IN_USED_W    = IN_WT_LSB + WEIGHT_W;
	localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

	// output word layout: out_vertex, joint_a..d, norm_weight_a..d
	localparam int OUT_JOINT_LSB = VTX_W;
	localparam int OUT_WT_LSB    = OUT_JOINT_LSB + EMIT_SLOTS * JOINT_W;
	localparam int OUT_USED_W    = OUT_WT_LSB + EMIT_SLOTS * WEIGHT_W;
	localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

	// command codes carried on tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

endpackage

// File: rtl/core/swta_ram.sv
module swta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/skin_weight_top4_accumulator.sv
// Top-four skin weight accumulator.
// Input channel s_axis: tuser carries the command (clear, add, finish), tdata the
// vertex, joint and Q0.16 weight. Output channel m_axis: one word per finish
// command with the vertex, its four joints and four normalized Q0.16 weights.
// A vertex record (four joint/weight slots) lives in a 4096-entry RAM with a
// registered read port; an add or finish works through a read-modify-write of it.
// A clear is written at acceptance. An add holds the input off through a read,
// a load, a scan of one slot per cycle through the shared add/subtract unit, an
// optional replace decision, then the write-back if a slot changed. A finish
// sums the slots one per cycle, then divides each weight by the sum with a restoring
// divider that retires one quotient bit per cycle through the same unit (skipped
// with a zero sum); its word enters the output register in the same cycle as the
// write-back, once the output register is free.
// s_axis_tready is high only while the sequencer is idle.
// The output register holds a word until it is taken; a finish that is done
// while the previous word still waits holds in place until m_axis_tready.
// Reset clears the sequencer and the output valid; the RAM is not cleared, and a
// vertex must see a clear before its first add or finish.
module skin_weight_top4_accumulator (
	input  logic                            clk,
	input  logic                            arst_n,
	// fields from bit 0: vertex_index[11:0], joint[19:12], weight[35:20]
	input  logic [swta_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// fields from bit 0: command[1:0]
	input  logic [swta_pkg::CMD_W-1:0]      s_axis_tuser,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// fields from bit 0: out_vertex[11:0], joint_a..joint_d[43:12],
	// norm_weight_a..norm_weight_d[107:44]
	output logic [swta_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready
);

	localparam int VTX_AW   = (swta_pkg::VERTEX_DEPTH > 1) ? $clog2(swta_pkg::VERTEX_DEPTH) : 1;
	localparam int SLOT_W   = (swta_pkg::SLOT_COUNT > 1) ? $clog2(swta_pkg::SLOT_COUNT) : 1;
	localparam int SLOT_CW  = $clog2(swta_pkg::SLOT_COUNT + 1);
	localparam int SUM_W    = swta_pkg::WEIGHT_W + SLOT_W;
	localparam int ALU_W    = SUM_W + 1;
	localparam int QUO_W    = swta_pkg::WEIGHT_W + 1;
	localparam int DIV_STEPS = QUO_W;
	localparam int STEP_W   = $clog2(DIV_STEPS);
	localparam int JREC_W   = swta_pkg::SLOT_COUNT * swta_pkg::JOINT_W;
	localparam int REC_W    = JREC_W + swta_pkg::SLOT_COUNT * swta_pkg::WEIGHT_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_LOAD,
		S_SCAN,
		S_DECIDE,
		S_WRITE,
		S_SUM,
		S_DIV,
		S_EMIT
	} state_t;

	state_t                          state_q;
	swta_pkg::cmd_t                  cmd_q;
	logic [swta_pkg::VTX_W-1:0]      vtx_q;
	logic [swta_pkg::JOINT_W-1:0]    joint_q;
	logic [swta_pkg::WEIGHT_W-1:0]   wt_q;
	logic [swta_pkg::JOINT_W-1:0]    joints_q  [swta_pkg::SLOT_COUNT];
	logic [swta_pkg::WEIGHT_W-1:0]   weights_q [swta_pkg::SLOT_COUNT];
	logic [SLOT_CW-1:0]              slot_q;
	logic [SLOT_W-1:0]               weak_idx_q;
	logic [swta_pkg::WEIGHT_W-1:0]   weak_w_q;
	logic [SUM_W-1:0]                sum_q;
	logic [SUM_W-1:0]                rem_q;
	logic [QUO_W-1:0]                dvd_q;
	logic [QUO_W-1:0]                quo_q;
	logic [STEP_W-1:0]               step_q;
	logic                            m_tvalid_q;
	logic [swta_pkg::OUT_DATA_W-1:0] m_tdata_q;

	// input field split
	swta_pkg::cmd_t                in_cmd;
	logic [swta_pkg::VTX_W-1:0]    in_vtx;
	logic [swta_pkg::JOINT_W-1:0]  in_joint;
	logic [swta_pkg::WEIGHT_W-1:0] in_wt;
	logic                          in_fire;
	logic                          in_vtx_ok;
	logic                          in_add_ok;

	assign in_cmd    = swta_pkg::cmd_t'(s_axis_tuser);
	assign in_vtx    = s_axis_tdata[swta_pkg::IN_VTX_LSB +: swta_pkg::VTX_W];
	assign in_joint  = s_axis_tdata[swta_pkg::IN_JOINT_LSB +: swta_pkg::JOINT_W];
	assign in_wt     = s_axis_tdata[swta_pkg::IN_WT_LSB +: swta_pkg::WEIGHT_W];
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign in_vtx_ok = 32'(in_vtx) < swta_pkg::VERTEX_DEPTH;
	assign in_add_ok = (in_wt != '0) && (32'(in_joint) < swta_pkg::JOINT_LIMIT);

	assign s_axis_tready = (state_q == S_IDLE);

	// slot pointers
	logic [SLOT_W-1:0] cur_idx;
	logic [SLOT_W-1:0] nxt_idx;
	logic              slot_last;
	logic              step_last;
	logic              out_free;

	assign cur_idx   = slot_q[SLOT_W-1:0];
	assign nxt_idx   = SLOT_W'(slot_q + 1'b1);
	assign slot_last = (slot_q == SLOT_CW'(swta_pkg::SLOT_COUNT - 1));
	assign step_last = (step_q == STEP_W'(DIV_STEPS - 1));
	assign out_free  = !m_tvalid_q || m_axis_tready;

	// shared add/subtract unit: slot compare, replace test, sum, divider trial
	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	logic             alu_sub;
	logic [ALU_W:0]   alu_res;
	logic             alu_lt;
	logic [ALU_W-1:0] div_shift;

	assign div_shift = {rem_q, dvd_q[QUO_W-1]};

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		case (state_q)
			S_SCAN: begin
				alu_a = ALU_W'(weights_q[cur_idx]);
				alu_b = ALU_W'(weak_w_q);
			end
			S_DECIDE: begin
				alu_a = ALU_W'(weak_w_q);
				alu_b = ALU_W'(wt_q);
			end
			S_SUM: begin
				alu_a   = ALU_W'(sum_q);
				alu_b   = ALU_W'(weights_q[cur_idx]);
				alu_sub = 1'b0;
			end
			S_DIV: begin
				alu_a = div_shift;
				alu_b = ALU_W'(sum_q);
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	assign alu_res = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b} + (ALU_W + 1)'(alu_sub);
	assign alu_lt  = alu_sub && !alu_res[ALU_W];

	// divider quotient with this cycle's bit, saturated to Q0.16
	logic [QUO_W-1:0]              quo_next;
	logic [swta_pkg::WEIGHT_W-1:0] quo_sat;

	assign quo_next = {quo_q[QUO_W-2:0], !alu_lt};
	assign quo_sat  = quo_next[QUO_W-1] ? '1 : quo_next[swta_pkg::WEIGHT_W-1:0];

	// record packing for the write-back
	logic [REC_W-1:0] rec_wdata;
	logic [REC_W-1:0] ram_rdata;

	always_comb begin
		rec_wdata = '0;
		for (int i = 0; i < swta_pkg::SLOT_COUNT; i++) begin
			rec_wdata[i*swta_pkg::JOINT_W +: swta_pkg::JOINT_W] = joints_q[i];
			rec_wdata[JREC_W + i*swta_pkg::WEIGHT_W +: swta_pkg::WEIGHT_W] = weights_q[i];
		end
	end

	// output word
	logic [swta_pkg::OUT_DATA_W-1:0] out_word;

	always_comb begin
		out_word = '0;
		out_word[swta_pkg::VTX_W-1:0] = vtx_q;
		for (int i = 0; i < swta_pkg::EMIT_SLOTS; i++) begin
			if (i < swta_pkg::SLOT_COUNT) begin
				out_word[swta_pkg::OUT_JOINT_LSB + i*swta_pkg::JOINT_W +: swta_pkg::JOINT_W] =
					joints_q[i];
				out_word[swta_pkg::OUT_WT_LSB + i*swta_pkg::WEIGHT_W +: swta_pkg::WEIGHT_W] =
					weights_q[i];
			end
		end
	end

	// ram write: clear at acceptance, write-back after add or finish
	logic              ram_we;
	logic [VTX_AW-1:0] ram_waddr;
	logic [REC_W-1:0]  ram_wdata;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = VTX_AW'(vtx_q);
		ram_wdata = rec_wdata;
		if (in_fire && in_vtx_ok && in_cmd == swta_pkg::CMD_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = VTX_AW'(in_vtx);
			ram_wdata = '0;
		end else if (state_q == S_WRITE || (state_q == S_EMIT && out_free)) begin
			ram_we = 1'b1;
		end
	end

	swta_ram #(
		.WIDTH(REC_W),
		.DEPTH(swta_pkg::VERTEX_DEPTH)
	) u_rec_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (VTX_AW'(vtx_q)),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= swta_pkg::CMD_CLEAR;
			vtx_q      <= '0;
			joint_q    <= '0;
			wt_q       <= '0;
			slot_q     <= '0;
			weak_idx_q <= '0;
			weak_w_q   <= '0;
			sum_q      <= '0;
			rem_q      <= '0;
			dvd_q      <= '0;
			quo_q      <= '0;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			for (int i = 0; i < swta_pkg::SLOT_COUNT; i++) begin
				joints_q[i]  <= '0;
				weights_q[i] <= '0;
			end
		end else begin
			// new word loaded, or word taken
			if (state_q == S_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cmd_q   <= in_cmd;
						vtx_q   <= in_vtx;
						joint_q <= in_joint;
						wt_q    <= in_wt;
						if (in_vtx_ok) begin
							case (in_cmd)
								swta_pkg::CMD_ADD: begin
									if (in_add_ok) begin
										state_q <= S_READ;
									end
								end
								swta_pkg::CMD_FINISH: begin
									state_q <= S_READ;
								end
								default: begin
									state_q <= S_IDLE;
								end
							endcase
						end
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					for (int i = 0; i < swta_pkg::SLOT_COUNT; i++) begin
						joints_q[i]  <= ram_rdata[i*swta_pkg::JOINT_W +: swta_pkg::JOINT_W];
						weights_q[i] <= ram_rdata[JREC_W + i*swta_pkg::WEIGHT_W +:
							swta_pkg::WEIGHT_W];
					end
					slot_q     <= '0;
					sum_q      <= '0;
					weak_idx_q <= '0;
					weak_w_q   <= ram_rdata[JREC_W +: swta_pkg::WEIGHT_W];
					state_q    <= (cmd_q == swta_pkg::CMD_ADD) ? S_SCAN : S_SUM;
				end
				// first empty slot wins, else track the lowest-indexed weakest
				S_SCAN: begin
					if (weights_q[cur_idx] == '0) begin
						joints_q[cur_idx]  <= joint_q;
						weights_q[cur_idx] <= wt_q;
						state_q            <= S_WRITE;
					end else begin
						if (alu_lt) begin
							weak_idx_q <= cur_idx;
							weak_w_q   <= weights_q[cur_idx];
						end
						if (slot_last) begin
							state_q <= S_DECIDE;
						end else begin
							slot_q <= slot_q + 1'b1;
						end
					end
				end
				// replace only when the new weight is strictly greater
				S_DECIDE: begin
					if (alu_lt) begin
						joints_q[weak_idx_q]  <= joint_q;
						weights_q[weak_idx_q] <= wt_q;
						state_q               <= S_WRITE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_WRITE: begin
					state_q <= S_IDLE;
				end
				S_SUM: begin
					sum_q <= alu_res[SUM_W-1:0];
					if (slot_last) begin
						slot_q <= '0;
						rem_q  <= SUM_W'(weights_q[0] >> 1);
						dvd_q  <= {weights_q[0][0], {swta_pkg::WEIGHT_W{1'b0}}};
						quo_q  <= '0;
						step_q <= '0;
						// zero sum: record stays as it is
						state_q <= (alu_res[SUM_W-1:0] == '0) ? S_EMIT : S_DIV;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				// restoring division, one quotient bit per cycle
				S_DIV: begin
					if (step_last) begin
						weights_q[cur_idx] <= quo_sat;
						step_q             <= '0;
						quo_q              <= '0;
						if (slot_last) begin
							state_q <= S_EMIT;
						end else begin
							slot_q <= slot_q + 1'b1;
							rem_q  <= SUM_W'(weights_q[nxt_idx] >> 1);
							dvd_q  <= {weights_q[nxt_idx][0], {swta_pkg::WEIGHT_W{1'b0}}};
						end
					end else begin
						rem_q  <= alu_lt ? div_shift[SUM_W-1:0] : alu_res[SUM_W-1:0];
						dvd_q  <= {dvd_q[QUO_W-2:0], 1'b0};
						quo_q  <= quo_next;
						step_q <= step_q + 1'b1;
					end
				end
				// present the word and write back in the same cycle
				S_EMIT: begin
					if (out_free) begin
						m_tdata_q <= out_word;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

endmodule

// File: rtl/core/swta_checker.sv
`include "skin_weight_top4_accumulator_defines.svh"

module swta_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic [swta_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic [swta_pkg::CMD_W-1:0]      s_axis_tuser,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [swta_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready
);

	logic in_fire;
	logic add_live;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign add_live = s_axis_tdata[swta_pkg::IN_WT_LSB +: swta_pkg::WEIGHT_W] != '0;

	// an add with a real weight occupies the sequencer
	`SWTA_ASSERT_NEXT(a_add_busy, in_fire && s_axis_tuser == swta_pkg::CMD_ADD && add_live, !s_axis_tready, "add did not hold off the next word")

	// a finish occupies the sequencer
	`SWTA_ASSERT_NEXT(a_finish_busy, in_fire && s_axis_tuser == swta_pkg::CMD_FINISH, !s_axis_tready, "finish did not hold off the next word")

	// a stalled result word holds
	`SWTA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")

	// a new result only comes out of a busy sequencer
	`SWTA_ASSERT_IMPL(a_out_from_busy, $rose(m_axis_tvalid), !$past(s_axis_tready), "result appeared while idle")

	// pad bits of the result word stay zero
	`SWTA_ASSERT_IMPL(a_out_pad, m_axis_tvalid, m_axis_tdata[swta_pkg::OUT_DATA_W-1:swta_pkg::OUT_USED_W] == '0, "result pad bits set")

endmodule

bind skin_weight_top4_accumulator swta_checker u_swta_checker (.*);
